### rtl/gdfs_pkg.sv
// Shared types and constants for the depth-first parent finder.
package gdfs_pkg;

  localparam int VERT_W   = 6;
  localparam int CFG_W    = 6;
  localparam int VERT_MAX = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // Input item kind codes
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Command handed from the front to the back
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RUN   = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [VERT_W-1:0] a;
    logic [VERT_W-1:0] b;
  } cmd_t;

endpackage

### rtl/gdfs_front.sv
// Front end: accepts input beats, classifies them and queues commands.
module gdfs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_kind,
  input  logic [gdfs_pkg::VERT_W-1:0] in_vertex_a,
  input  logic [gdfs_pkg::VERT_W-1:0] in_vertex_b,
  output logic                       cmd_valid,
  output gdfs_pkg::cmd_t             cmd,
  input  logic                       cmd_take
);

  gdfs_pkg::cmd_t q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           accept;
  logic           push;
  gdfs_pkg::cmd_t cls;
  logic           cls_ok;

  // Classify the incoming beat; unused kind is dropped
  always_comb begin
    cls.a  = in_vertex_a;
    cls.b  = in_vertex_b;
    cls.op = gdfs_pkg::OP_ADD;
    cls_ok = 1'b1;
    case (gdfs_pkg::kind_t'(in_kind))
      gdfs_pkg::KIND_ADD:   cls.op = gdfs_pkg::OP_ADD;
      gdfs_pkg::KIND_CLEAR: cls.op = gdfs_pkg::OP_CLEAR;
      gdfs_pkg::KIND_RUN:   cls.op = gdfs_pkg::OP_RUN;
      default:              cls_ok = 1'b0;
    endcase
  end

  assign in_stall  = (count_r == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign push      = accept && cls_ok;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, cmd_take})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> count_r != 2'd0) else $error("command taken from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cmd_take) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count missed a push");
`endif

endmodule

### rtl/gdfs_back.sv
// Back end: graph store, stack-based depth-first search and result output.
module gdfs_back #(
  parameter int STACK_DEPTH  = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gdfs_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        cmd_valid,
  input  gdfs_pkg::cmd_t              cmd,
  output logic                        cmd_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gdfs_pkg::VERT_W-1:0] out_vertex,
  output logic [gdfs_pkg::VERT_W-1:0] out_parent_vertex,
  output logic                        out_last,
  output logic                        out_overflow
);

  localparam int VW  = $clog2(gdfs_pkg::VERT_MAX + 1);
  localparam int AW  = $clog2(gdfs_pkg::VERT_MAX);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ROOT, S_POP, S_CHECK, S_SCAN, S_EMIT_RD, S_EMIT_WR
  } state_t;

  state_t                           state_r;
  logic [gdfs_pkg::CFG_W-1:0]       cfg_r;
  logic [gdfs_pkg::VERT_MAX-1:0]    adj_r [gdfs_pkg::VERT_MAX];
  logic [gdfs_pkg::VERT_MAX-1:0]    vis_r;
  logic [gdfs_pkg::VERT_MAX-1:0]    row_r;
  logic                             ovf_r;
  logic [SPW-1:0]                   sp_r;
  logic [VW-1:0]                    i_r;
  logic [VW-1:0]                    u_r;
  logic [VW-1:0]                    v_r;
  logic                             out_valid_r;
  logic [gdfs_pkg::VERT_W-1:0]      out_vertex_r;
  logic [gdfs_pkg::VERT_W-1:0]      out_parent_r;
  logic                             out_last_r;
  logic                             out_ovf_r;

  logic [VW-1:0]                    stk_mem [STACK_DEPTH];
  logic [VW-1:0]                    stk_rd_r;
  logic [gdfs_pkg::VERT_W-1:0]      par_mem [gdfs_pkg::VERT_MAX];
  logic [gdfs_pkg::VERT_W-1:0]      par_rd_r;

  logic [VW-1:0]                    n;
  logic                             edge_ok;
  logic [AW-1:0]                    a_idx, b_idx, i_idx, u_idx, v_idx;
  logic [SPW-1:0]                   sp_dec;
  logic                             root_push;
  logic                             scan_hit;
  logic                             scan_push;
  logic                             u_bad;
  logic                             out_load;
  logic                             stk_we;
  logic [SAW-1:0]                   stk_waddr;
  logic [VW-1:0]                    stk_wdata;
  logic                             par_we;
  logic [AW-1:0]                    par_waddr;
  logic [gdfs_pkg::VERT_W-1:0]      par_wdata;

  // Clamp the vertex count to the supported range
  always_comb begin
    if (cfg_r == '0) begin
      n = VW'(1);
    end else if (32'(cfg_r) > gdfs_pkg::VERT_MAX) begin
      n = VW'(gdfs_pkg::VERT_MAX);
    end else begin
      n = VW'(cfg_r);
    end
  end

  assign a_idx   = AW'(cmd.a - 6'd1);
  assign b_idx   = AW'(cmd.b - 6'd1);
  assign i_idx   = AW'(i_r - VW'(1));
  assign u_idx   = AW'(stk_rd_r - VW'(1));
  assign v_idx   = AW'(v_r - VW'(1));
  assign sp_dec  = sp_r - SPW'(1);
  assign edge_ok = (cmd.a != '0) && (cmd.b != '0) &&
                   (32'(cmd.a) <= 32'(n)) && (32'(cmd.b) <= 32'(n));

  // Search decisions for this cycle
  assign root_push = (state_r == S_ROOT) && (32'(i_r) <= 32'(n)) && !vis_r[i_idx];
  assign u_bad     = (stk_rd_r == '0) || (32'(stk_rd_r) > 32'(n)) || vis_r[u_idx];
  assign scan_hit  = (state_r == S_SCAN) && row_r[v_idx] && !vis_r[v_idx];
  assign scan_push = scan_hit && (sp_r != SP_FULL);
  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign out_load  = (state_r == S_EMIT_WR) && (!out_valid_r || !out_stall);

  // Stack and parent write ports
  always_comb begin
    stk_we    = root_push || scan_push;
    stk_waddr = root_push ? '0 : SAW'(sp_r);
    stk_wdata = root_push ? i_r : v_r;
    par_we    = root_push || scan_push;
    par_waddr = root_push ? i_idx : v_idx;
    par_wdata = root_push ? '0 : gdfs_pkg::VERT_W'(u_r);
  end

  // Search stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[SAW'(sp_dec)];
  end

  // Parent memory
  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rd_r <= par_mem[i_idx];
  end

  // Sequencer, graph store and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= gdfs_pkg::CFG_RESET;
      adj_r       <= '{default: '0};
      vis_r       <= '0;
      ovf_r       <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              gdfs_pkg::OP_ADD: begin
                if (edge_ok) begin
                  adj_r[a_idx][b_idx] <= 1'b1;
                  adj_r[b_idx][a_idx] <= 1'b1;
                end
              end
              gdfs_pkg::OP_CLEAR: adj_r <= '{default: '0};
              gdfs_pkg::OP_RUN:   state_r <= S_INIT;
              default: ;
            endcase
          end
        end
        S_INIT: begin
          vis_r   <= '0;
          ovf_r   <= 1'b0;
          sp_r    <= '0;
          i_r     <= VW'(1);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (32'(i_r) > 32'(n)) begin
            i_r     <= VW'(1);
            state_r <= S_EMIT_RD;
          end else if (vis_r[i_idx]) begin
            i_r <= i_r + VW'(1);
          end else begin
            sp_r    <= SPW'(1);
            state_r <= S_POP;
          end
        end
        S_POP: begin
          if (sp_r == '0) begin
            i_r     <= i_r + VW'(1);
            state_r <= S_ROOT;
          end else begin
            sp_r    <= sp_dec;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (u_bad) begin
            state_r <= S_POP;
          end else begin
            vis_r[u_idx] <= 1'b1;
            row_r        <= adj_r[u_idx];
            u_r          <= stk_rd_r;
            v_r          <= VW'(1);
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            if (sp_r == SP_FULL) begin
              ovf_r <= 1'b1;
            end else begin
              sp_r <= sp_r + SPW'(1);
            end
          end
          if (v_r == n) begin
            state_r <= S_POP;
          end else begin
            v_r <= v_r + VW'(1);
          end
        end
        S_EMIT_RD: state_r <= S_EMIT_WR;
        S_EMIT_WR: begin
          if (out_load) begin
            out_vertex_r <= gdfs_pkg::VERT_W'(i_r);
            out_parent_r <= par_rd_r;
            out_last_r   <= (i_r == n);
            out_ovf_r    <= ovf_r;
            if (i_r == n) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + VW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex        = out_vertex_r;
  assign out_parent_vertex = out_parent_r;
  assign out_last          = out_last_r;
  assign out_overflow      = out_ovf_r;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_FULL) else $error("stack pointer past depth");
  a_ovf_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(state_r == S_SCAN)) else $error("overflow raised outside scan");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT_WR))
    else $error("result loaded outside emit");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    scan_push |-> sp_r < SP_FULL) else $error("push into full stack");
`endif

endmodule

### rtl/graph_dfs_parent_finder_unit.sv
// Top level of the depth-first parent finder: front queue plus search engine.
//
// Add-edge and clear-graph beats are executed by the engine directly from idle.
// A traversal sweeps the roots in order; each unvisited vertex popped off the
// stack has its row scanned, one neighbor tested per cycle, after a registered
// stack read, and a popped vertex that is already visited is skipped; each
// result beat waits while the receiver stalls. A two-entry command queue lets
// new beats be taken while a traversal runs. Vertex count (cfg) is clamped to
// 1..32 and is to be written only while the block is idle.
module graph_dfs_parent_finder_unit #(
  parameter int STACK_DEPTH  = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gdfs_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [gdfs_pkg::VERT_W-1:0] in_vertex_a,
  input  logic [gdfs_pkg::VERT_W-1:0] in_vertex_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gdfs_pkg::VERT_W-1:0] out_vertex,
  output logic [gdfs_pkg::VERT_W-1:0] out_parent_vertex,
  output logic                        out_last,
  output logic                        out_overflow
);

  logic           cmd_valid;
  logic           cmd_take;
  gdfs_pkg::cmd_t cmd;

  // Accept and classify beats
  gdfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // Execute commands and emit parents
  gdfs_back #(
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vertex        (out_vertex),
    .out_parent_vertex (out_parent_vertex),
    .out_last          (out_last),
    .out_overflow      (out_overflow)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for the depth-first parent finder unit.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_V      = 32;
  localparam int STACK_MAX  = 1024;
  localparam int QUIET_WAIT = 40;
  localparam int STALL_LIMIT = 200000;
  localparam int NO_CFG     = -1;

  typedef struct {
    logic [gdfs_pkg::VERT_W-1:0] vertex;
    logic [gdfs_pkg::VERT_W-1:0] parent;
    logic                        last;
    logic                        overflow;
  } parent_beat_t;

  typedef struct {
    int                          cfg;
    gdfs_pkg::kind_t             kind;
    logic [gdfs_pkg::VERT_W-1:0] a;
    logic [gdfs_pkg::VERT_W-1:0] b;
    bit                          all_roots;
  } row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [gdfs_pkg::CFG_W-1:0]  cfg_wr_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_kind;
  logic [gdfs_pkg::VERT_W-1:0] in_vertex_a;
  logic [gdfs_pkg::VERT_W-1:0] in_vertex_b;
  logic                        out_valid;
  logic                        out_stall;
  logic [gdfs_pkg::VERT_W-1:0] out_vertex;
  logic [gdfs_pkg::VERT_W-1:0] out_parent_vertex;
  logic                        out_last;
  logic                        out_overflow;

  // Mirror of the graph state
  logic [MAX_V-1:0]            adj_rows [1:MAX_V];
  logic [gdfs_pkg::CFG_W-1:0]  count_reg;
  parent_beat_t                parents_due[$];
  int                          errors;
  int                          send_idle_pct;
  int                          recv_stall_pct;
  int                          quiet_cycles;

  graph_dfs_parent_finder_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .out_valid(out_valid), .out_stall(out_stall), .out_vertex(out_vertex),
    .out_parent_vertex(out_parent_vertex), .out_last(out_last),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int active_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_V) return MAX_V;
    return count_reg;
  endfunction

  // Apply one beat to the mirror and queue the parents a traversal reports
  function automatic void predict_parents(gdfs_pkg::kind_t kind, int a, int b);
    int n;
    int sp;
    int u;
    bit ovf;
    bit seen [1:MAX_V];
    int par [1:MAX_V];
    int stk [STACK_MAX];
    parent_beat_t r;
    n = active_count();
    case (kind)
      gdfs_pkg::KIND_ADD: begin
        if (a != 0 && b != 0 && a <= n && b <= n) begin
          adj_rows[a][b-1] = 1'b1;
          adj_rows[b][a-1] = 1'b1;
        end
      end
      gdfs_pkg::KIND_CLEAR: begin
        for (int i = 1; i <= MAX_V; i++) adj_rows[i] = '0;
      end
      gdfs_pkg::KIND_RUN: begin
        ovf = 1'b0;
        for (int i = 1; i <= MAX_V; i++) begin
          seen[i] = 1'b0;
          par[i] = 0;
        end
        for (int root = 1; root <= n; root++) begin
          if (seen[root]) continue;
          sp = 0;
          stk[sp++] = root;
          par[root] = 0;
          while (sp != 0) begin
            sp--;
            u = stk[sp];
            if (seen[u]) continue;
            seen[u] = 1'b1;
            for (int v = 1; v <= n; v++) begin
              if (!adj_rows[u][v-1] || seen[v]) continue;
              if (sp >= STACK_MAX) begin
                ovf = 1'b1;
                continue;
              end
              stk[sp++] = v;
              par[v] = u;
            end
          end
        end
        for (int i = 1; i <= n; i++) begin
          r.vertex = gdfs_pkg::VERT_W'(i);
          r.parent = gdfs_pkg::VERT_W'(par[i]);
          r.last = (i == n);
          r.overflow = ovf;
          parents_due = {parents_due, r};
        end
      end
      default: ;
    endcase
  endfunction

  // Send one beat, with random idle cycles ahead of it
  task automatic send_beat(gdfs_pkg::kind_t kind, logic [gdfs_pkg::VERT_W-1:0] a,
                           logic [gdfs_pkg::VERT_W-1:0] b, bit all_roots);
    parent_beat_t r;
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_vertex_a <= a;
    in_vertex_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (all_roots) begin
      // Empty graph at this count: every vertex is a root, no overflow
      n = active_count();
      for (int i = 1; i <= n; i++) begin
        r.vertex = gdfs_pkg::VERT_W'(i);
        r.parent = '0;
        r.last = (i == n);
        r.overflow = 1'b0;
        parents_due = {parents_due, r};
      end
    end else begin
      predict_parents(kind, a, b);
    end
  endtask

  // Hold until every expected beat is out and the engine has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (parents_due.size() != 0) @(posedge clk);
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  task automatic set_count(int value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gdfs_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    count_reg = gdfs_pkg::CFG_W'(value);
  endtask

  task automatic send_random();
    int n;
    int r;
    n = active_count();
    r = $urandom_range(99);
    if (r < 8) begin
      send_beat(gdfs_pkg::KIND_RUN, gdfs_pkg::VERT_W'($urandom),
                gdfs_pkg::VERT_W'($urandom), 1'b0);
    end else if (r < 11) begin
      send_beat(gdfs_pkg::KIND_CLEAR, gdfs_pkg::VERT_W'($urandom),
                gdfs_pkg::VERT_W'($urandom), 1'b0);
    end else if (r < 14) begin
      send_beat(gdfs_pkg::KIND_NONE, gdfs_pkg::VERT_W'($urandom),
                gdfs_pkg::VERT_W'($urandom), 1'b0);
    end else if (r < 18) begin
      send_beat(gdfs_pkg::KIND_ADD, gdfs_pkg::VERT_W'($urandom),
                gdfs_pkg::VERT_W'($urandom), 1'b0);
    end else begin
      send_beat(gdfs_pkg::KIND_ADD, gdfs_pkg::VERT_W'($urandom_range(n, 1)),
                gdfs_pkg::VERT_W'($urandom_range(n, 1)), 1'b0);
    end
  endtask

  // Drive the receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic check_field(string name, int expv, int got);
    if (expv != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, expv, got);
      errors++;
    end
  endtask

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    parent_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (parents_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual vertex %0d parent %0d",
                 $realtime, out_vertex, out_parent_vertex);
        errors++;
      end else begin
        e = parents_due.pop_front();
        check_field("vertex", e.vertex, out_vertex);
        check_field("parent_vertex", e.parent, out_parent_vertex);
        check_field("last", e.last, out_last);
        check_field("overflow", e.overflow, out_overflow);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  row_t rows [$];

  initial begin
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    count_reg = gdfs_pkg::CFG_RESET;
    for (int i = 1; i <= MAX_V; i++) adj_rows[i] = '0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_kind = '0;
    in_vertex_a = '0;
    in_vertex_b = '0;
    out_stall = 1'b0;

    rows = '{
      '{NO_CFG, gdfs_pkg::KIND_RUN,   6'd0,  6'd0,  1'b1},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd1,  6'd2,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd2,  6'd3,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd1,  6'd3,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd0,  6'd5,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd33, 6'd1,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd63, 6'd63, 1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd32, 6'd32, 1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd5,  6'd32, 1'b0},
      '{NO_CFG, gdfs_pkg::KIND_NONE,  6'd63, 6'd63, 1'b0},
      '{NO_CFG, gdfs_pkg::KIND_RUN,   6'd0,  6'd0,  1'b0},
      '{4,      gdfs_pkg::KIND_ADD,   6'd1,  6'd4,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd4,  6'd5,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_RUN,   6'd63, 6'd0,  1'b0},
      '{0,      gdfs_pkg::KIND_RUN,   6'd0,  6'd0,  1'b1},
      '{63,     gdfs_pkg::KIND_ADD,   6'd7,  6'd8,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_ADD,   6'd31, 6'd30, 1'b0},
      '{NO_CFG, gdfs_pkg::KIND_RUN,   6'd0,  6'd0,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_CLEAR, 6'd0,  6'd0,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_RUN,   6'd0,  6'd0,  1'b1},
      '{1,      gdfs_pkg::KIND_ADD,   6'd1,  6'd1,  1'b0},
      '{NO_CFG, gdfs_pkg::KIND_RUN,   6'd0,  6'd0,  1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    foreach (rows[i]) begin
      if (rows[i].cfg != NO_CFG) set_count(rows[i].cfg);
      send_beat(rows[i].kind, rows[i].a, rows[i].b, rows[i].all_roots);
    end

    // Random phases with different idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      set_count(phase == 0 ? 32 : $urandom_range(32, 1));
      for (int k = 0; k < 28; k++) begin
        if (phase == 2 && k == 14) drain();
        send_random();
      end
      send_beat(gdfs_pkg::KIND_RUN, '0, '0, 1'b0);
    end

    drain();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
